[src/bra_pkg.sv]
`default_nettype none

package bra_pkg;

    localparam int CHUNK = 8;

    typedef enum logic [3:0] {
        OP_SET         = 4'd0,
        OP_CLEAR       = 4'd1,
        OP_TEST_CLEAR  = 4'd2,
        OP_TEST_SET    = 4'd3,
        OP_FIND_CLEAR  = 4'd4,
        OP_FIND_SET    = 4'd5,
        OP_CLAIM_CLEAR = 4'd6,
        OP_CLAIM_SET   = 4'd7,
        OP_FIRST_CLEAR = 4'd8,
        OP_FIRST_SET   = 4'd9,
        OP_LONG_CLEAR  = 4'd10,
        OP_LONG_SET    = 4'd11,
        OP_COUNT_CLEAR = 4'd12,
        OP_COUNT_SET   = 4'd13,
        OP_FILL_CLEAR  = 4'd14,
        OP_FILL_SET    = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        MD_NONE  = 3'd0,
        MD_TEST  = 3'd1,
        MD_FIND  = 3'd2,
        MD_FIRST = 3'd3,
        MD_LONG  = 3'd4,
        MD_COUNT = 3'd5
    } t_mode;

    typedef struct packed {
        logic start;
        logic begin_write;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pass_done;
        logic need_write;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[src/bitmap_range_allocator_top.sv]
// Bit map allocator with range set, clear and test, first-fit search with
// optional claim, first and longest run reports, bit counts and fill.
// Requests arrive on i_in_valid / o_in_ready with operation, position and
// length; each request gives exactly one result on o_out_valid / i_out_ready.
// The map size register is written through i_cfg_we / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// One request is processed at a time. A scan walks the map from bit zero in
// steps of eight bits, one step per cycle, and a word boundary ends a step
// early. The scan ends early once a test fails, a search finds its run or a
// first run ends. A claim, range change or fill adds a write pass over the
// map from bit zero up to the end of the changed range.
// Reset clears the map and sets the size register to 1024.
// The finished result sits in an output register; a new request is taken
// while it waits, and only the next result is held back until the receiver
// takes the previous one.
`default_nettype none

module bitmap_range_allocator_top #(
    parameter int BITS      = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic [10:0] i_position_index,
    input  wire logic [10:0] i_run_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_success,
    output logic [9:0]       o_result_index,
    output logic [10:0]      o_result_count
);

    bra_pkg::t_cmd cmd;
    bra_pkg::t_sts sts;

    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bra_datapath #(
        .BITS      (BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_position_index (i_position_index),
        .i_run_length     (i_run_length),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_success        (o_success),
        .o_result_index   (o_result_index),
        .o_result_count   (o_result_count),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

`default_nettype wire

[src/bra_datapath.sv]
`default_nettype none

module bra_datapath #(
    parameter int BITS      = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [10:0]   i_cfg_data,
    input  wire logic [3:0]    i_operation,
    input  wire logic [10:0]   i_position_index,
    input  wire logic [10:0]   i_run_length,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic               o_success,
    output logic [9:0]         o_result_index,
    output logic [10:0]        o_result_count,
    input  wire bra_pkg::t_cmd i_cmd,
    output bra_pkg::t_sts      o_sts
);

    localparam int NUM_WORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFW       = $clog2(WORD_BITS);
    localparam int AW        = (($clog2(BITS + 1) > 11) ? $clog2(BITS + 1) : 11) + 2;
    localparam logic [AW-1:0]  BITS_A = AW'(BITS);
    localparam logic [AW-1:0]  WB_A   = AW'(WORD_BITS);
    localparam logic [OFW:0]   WB_O   = (OFW+1)'(WORD_BITS);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [10:0]          r_size;

    bra_pkg::t_mode r_mode;
    logic [AW-1:0]  r_len, r_slo, r_shi, r_wlo, r_whi;
    logic           r_want, r_wval, r_wr, r_write_op, r_claim, r_test_ok;

    logic [AW-1:0]  r_i;
    logic [WA-1:0]  r_w;
    logic [OFW-1:0] r_off;

    logic [AW-1:0]  r_run, r_best, r_bstart, r_cnt, r_fidx;
    logic           r_fail, r_found, r_phase, r_stop;

    logic           r_out_valid, r_succ;
    logic [9:0]     r_ridx;
    logic [10:0]    r_rcnt;

    logic [AW-1:0]  s_eff, d_pos, d_len, d_pend, d_clip, d_lim8, d_lim;
    bra_pkg::t_mode d_mode;
    logic [AW-1:0]  d_slo, d_shi, d_wlo, d_whi;
    logic           d_wval, d_write_op, d_claim, d_test_ok;

    always_comb begin
        s_eff  = (AW'(r_size) > BITS_A) ? BITS_A : AW'(r_size);
        d_pos  = AW'(i_position_index);
        d_len  = AW'(i_run_length);
        d_pend = d_pos + d_len;
        d_clip = (d_pend > s_eff) ? s_eff : d_pend;
        d_lim8 = (s_eff + AW'(7)) & ~AW'(7);
        d_lim  = (d_lim8 > BITS_A) ? BITS_A : d_lim8;
        d_mode     = bra_pkg::MD_NONE;
        d_slo      = '0;
        d_shi      = '0;
        d_wlo      = '0;
        d_whi      = '0;
        d_wval     = i_operation[0];
        d_write_op = 1'b0;
        d_claim    = 1'b0;
        d_test_ok  = 1'b0;
        unique case (bra_pkg::t_op'(i_operation)) inside
            bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
                d_write_op = 1'b1;
                d_wval     = (bra_pkg::t_op'(i_operation) == bra_pkg::OP_SET);
                d_wlo      = d_pos;
                d_whi      = (d_pos >= s_eff || d_len == '0) ? '0 : d_clip;
            end
            bra_pkg::OP_TEST_CLEAR, bra_pkg::OP_TEST_SET: begin
                d_mode    = bra_pkg::MD_TEST;
                d_test_ok = (d_pos < s_eff) && (d_len != '0) && (d_pend <= s_eff);
                d_slo     = d_pos;
                d_shi     = d_test_ok ? d_pend : '0;
            end
            bra_pkg::OP_FIND_CLEAR, bra_pkg::OP_FIND_SET,
            bra_pkg::OP_CLAIM_CLEAR, bra_pkg::OP_CLAIM_SET: begin
                d_mode  = bra_pkg::MD_FIND;
                d_slo   = (d_pos >= s_eff) ? '0 : d_pos;
                d_shi   = (d_len != '0 && d_len <= s_eff) ? s_eff : '0;
                d_claim = i_operation[1];
                d_wval  = ~i_operation[0];
            end
            bra_pkg::OP_FIRST_CLEAR, bra_pkg::OP_FIRST_SET: begin
                d_mode = bra_pkg::MD_FIRST;
                d_slo  = d_pos;
                d_shi  = s_eff;
            end
            bra_pkg::OP_LONG_CLEAR, bra_pkg::OP_LONG_SET: begin
                d_mode = bra_pkg::MD_LONG;
                d_shi  = s_eff;
            end
            bra_pkg::OP_COUNT_CLEAR, bra_pkg::OP_COUNT_SET: begin
                d_mode = bra_pkg::MD_COUNT;
                d_shi  = s_eff;
            end
            default: begin
                d_write_op = 1'b1;
                d_whi      = d_lim;
            end
        endcase
    end

    logic [AW-1:0]           p_lo, p_hi;
    logic [WORD_BITS-1:0]    cur_word;
    logic [bra_pkg::CHUNK-1:0] w_en;
    logic [OFW-1:0]          w_idx [bra_pkg::CHUNK];
    logic [AW-1:0]           n_run, n_best, n_bstart, n_cnt, n_fidx;
    logic                    n_fail, n_found, n_phase, n_stop;

    assign p_lo     = r_wr ? r_wlo : r_slo;
    assign p_hi     = r_wr ? r_whi : r_shi;
    assign cur_word = r_mem[r_w];

    always_comb begin
        logic [OFW:0]  offj;
        logic [AW-1:0] absj;
        logic          inr;
        logic          b;
        n_run    = r_run;
        n_best   = r_best;
        n_bstart = r_bstart;
        n_cnt    = r_cnt;
        n_fidx   = r_fidx;
        n_fail   = r_fail;
        n_found  = r_found;
        n_phase  = r_phase;
        n_stop   = r_stop;
        for (int j = 0; j < bra_pkg::CHUNK; j++) begin
            offj     = {1'b0, r_off} + (OFW+1)'(j);
            absj     = r_i + AW'(j);
            inr      = (offj < WB_O) && (absj >= p_lo) && (absj < p_hi) &&
                       (r_wr || !n_stop);
            b        = inr && (cur_word[offj[OFW-1:0]] == r_want);
            w_en[j]  = inr;
            w_idx[j] = offj[OFW-1:0];
            if (inr) begin
                case (r_mode)
                    bra_pkg::MD_TEST: begin
                        if (!b) begin
                            n_fail = 1'b1;
                            n_stop = 1'b1;
                        end
                    end
                    bra_pkg::MD_FIND: begin
                        if (b) begin
                            n_run = n_run + AW'(1);
                            if (n_run >= r_len) begin
                                n_found = 1'b1;
                                n_fidx  = absj + AW'(1) - r_len;
                                n_stop  = 1'b1;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                    bra_pkg::MD_FIRST: begin
                        if (!n_phase) begin
                            if (b) begin
                                n_phase = 1'b1;
                                n_found = 1'b1;
                                n_fidx  = absj;
                                n_cnt   = AW'(1);
                            end
                        end else if (b) begin
                            n_cnt = n_cnt + AW'(1);
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                    bra_pkg::MD_LONG: begin
                        if (b) begin
                            n_run = n_run + AW'(1);
                            if (n_run > n_best) begin
                                n_best   = n_run;
                                n_bstart = absj + AW'(1) - n_run;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                    bra_pkg::MD_COUNT: begin
                        if (b) begin
                            n_cnt = n_cnt + AW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    logic [OFW:0]   off_sum;
    logic [AW-1:0]  n_i;
    logic [WA-1:0]  n_w;
    logic [OFW-1:0] n_off;

    always_comb begin
        off_sum = {1'b0, r_off} + (OFW+1)'(bra_pkg::CHUNK);
        if (off_sum >= WB_O) begin
            n_w   = r_w + WA'(1);
            n_off = '0;
            n_i   = r_i + (WB_A - AW'(r_off));
        end else begin
            n_w   = r_w;
            n_off = off_sum[OFW-1:0];
            n_i   = r_i + AW'(bra_pkg::CHUNK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_mem[k] <= '0;
            end
        end else if (r_wr && i_cmd.step) begin
            for (int j = 0; j < bra_pkg::CHUNK; j++) begin
                if (w_en[j]) begin
                    r_mem[r_w][w_idx[j]] <= r_wval;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 11'd1024;
            r_wr   <= 1'b0;
            r_stop <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_mode     <= d_mode;
                r_len      <= d_len;
                r_want     <= i_operation[0];
                r_slo      <= d_slo;
                r_shi      <= d_shi;
                r_wlo      <= d_wlo;
                r_whi      <= d_whi;
                r_wval     <= d_wval;
                r_write_op <= d_write_op;
                r_claim    <= d_claim;
                r_test_ok  <= d_test_ok;
                r_wr       <= 1'b0;
                r_i        <= '0;
                r_w        <= '0;
                r_off      <= '0;
                r_run      <= '0;
                r_best     <= '0;
                r_bstart   <= '0;
                r_cnt      <= '0;
                r_fidx     <= '0;
                r_fail     <= 1'b0;
                r_found    <= 1'b0;
                r_phase    <= 1'b0;
                r_stop     <= 1'b0;
            end else if (i_cmd.begin_write) begin
                r_wr   <= 1'b1;
                r_i    <= '0;
                r_w    <= '0;
                r_off  <= '0;
                r_stop <= 1'b0;
                if (r_claim) begin
                    r_wlo <= r_fidx;
                    r_whi <= r_fidx + r_len;
                end
            end else if (i_cmd.step) begin
                r_i   <= n_i;
                r_w   <= n_w;
                r_off <= n_off;
                if (!r_wr) begin
                    r_run    <= n_run;
                    r_best   <= n_best;
                    r_bstart <= n_bstart;
                    r_cnt    <= n_cnt;
                    r_fidx   <= n_fidx;
                    r_fail   <= n_fail;
                    r_found  <= n_found;
                    r_phase  <= n_phase;
                    r_stop   <= n_stop;
                end
            end
        end
    end

    logic           res_succ;
    logic [AW-1:0]  res_idx, res_cnt;

    always_comb begin
        res_succ = 1'b0;
        res_idx  = '0;
        res_cnt  = '0;
        case (r_mode)
            bra_pkg::MD_TEST: begin
                res_succ = r_test_ok && !r_fail;
            end
            bra_pkg::MD_FIND: begin
                res_succ = r_found;
                res_idx  = r_found ? r_fidx : '0;
                res_cnt  = r_found ? r_len : '0;
            end
            bra_pkg::MD_FIRST: begin
                res_succ = r_found;
                res_idx  = r_found ? r_fidx : '0;
                res_cnt  = r_found ? r_cnt : '0;
            end
            bra_pkg::MD_LONG: begin
                res_succ = (r_best != '0);
                res_idx  = r_bstart;
                res_cnt  = r_best;
            end
            bra_pkg::MD_COUNT: begin
                res_cnt = r_cnt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
            r_succ      <= res_succ;
            r_ridx      <= res_idx[9:0];
            r_rcnt      <= res_cnt[10:0];
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_success       = r_succ;
    assign o_result_index  = r_ridx;
    assign o_result_count  = r_rcnt;
    assign o_sts.pass_done  = r_stop || (r_i >= p_hi);
    assign o_sts.need_write = r_write_op || (r_claim && r_found);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

[src/bra_ctrl.sv]
`default_nettype none

module bra_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bra_pkg::t_sts i_sts,
    output bra_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.pass_done) begin
                    if (i_sts.need_write) begin
                        o_cmd.begin_write = 1'b1;
                        n_state           = ST_WRITE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_WRITE: begin
                if (i_sts.pass_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == ST_SCAN)
        else $error("request start did not enter the scan pass");

    a_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && !i_sts.pass_done) |=> r_state == ST_WRITE)
        else $error("write pass left before its end");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

[tb/bitmap_range_allocator_checker.sv]
`default_nettype none

module bitmap_range_allocator_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic [10:0] i_position_index,
    input  wire logic [10:0] i_run_length,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_success,
    input  wire logic [9:0]  i_result_index,
    input  wire logic [10:0] i_result_count,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);

    localparam int NBITS = 1024;

    typedef struct packed {
        logic        success;
        logic [9:0]  index;
        logic [10:0] count;
    } t_alloc_result;

    logic [NBITS-1:0] shadow_map;
    logic [10:0]      shadow_size;
    t_alloc_result    expected_q[$];

    function automatic int map_limit();
        return (shadow_size > NBITS) ? NBITS : int'(shadow_size);
    endfunction

    task automatic write_range(input int start, input int len, input logic val);
        int s;
        s = map_limit();
        if (start >= s || len == 0) return;
        if (start + len > s) len = s - start;
        for (int i = start; i < start + len; i++) shadow_map[i] = val;
    endtask

    task automatic predict_allocation(input bra_pkg::t_op op, input int pos, input int len,
                                      output t_alloc_result r);
        int s, i, run, best, bstart, lim;
        logic want;
        s = map_limit();
        r = '0;
        want = op[0];
        case (op)
            bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
                write_range(pos, len, op == bra_pkg::OP_SET);
            end
            bra_pkg::OP_TEST_CLEAR, bra_pkg::OP_TEST_SET: begin
                if (!(pos >= s || len == 0 || pos + len > s)) begin
                    r.success = 1'b1;
                    for (i = pos; i < pos + len; i++)
                        if (shadow_map[i] != want) r.success = 1'b0;
                end
            end
            bra_pkg::OP_FIND_CLEAR, bra_pkg::OP_FIND_SET,
            bra_pkg::OP_CLAIM_CLEAR, bra_pkg::OP_CLAIM_SET: begin
                if (len != 0 && len <= s) begin
                    if (pos >= s) pos = 0;
                    run = 0;
                    for (i = pos; i < s; i++) begin
                        if (shadow_map[i] == want) begin
                            run++;
                            if (run >= len) begin
                                r.success = 1'b1;
                                r.index = 10'(i + 1 - len);
                                r.count = 11'(len);
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (r.success && (op == bra_pkg::OP_CLAIM_CLEAR ||
                                      op == bra_pkg::OP_CLAIM_SET))
                        write_range(i + 1 - len, len, !want);
                end
            end
            bra_pkg::OP_FIRST_CLEAR, bra_pkg::OP_FIRST_SET: begin
                i = pos;
                while (i < s && shadow_map[i] != want) i++;
                if (i < s) begin
                    r.success = 1'b1;
                    r.index = 10'(i);
                    while (i < s && shadow_map[i] == want) begin
                        r.count++;
                        i++;
                    end
                end
            end
            bra_pkg::OP_LONG_CLEAR, bra_pkg::OP_LONG_SET: begin
                run = 0;
                best = 0;
                bstart = 0;
                for (i = 0; i < s; i++) begin
                    if (shadow_map[i] == want) begin
                        run++;
                        if (run > best) begin
                            best = run;
                            bstart = i + 1 - run;
                        end
                    end else begin
                        run = 0;
                    end
                end
                if (best > 0) begin
                    r.success = 1'b1;
                    r.index = 10'(bstart);
                    r.count = 11'(best);
                end
            end
            bra_pkg::OP_COUNT_CLEAR, bra_pkg::OP_COUNT_SET: begin
                for (i = 0; i < s; i++)
                    if (shadow_map[i] == want) r.count++;
            end
            default: begin
                lim = (s + 7) / 8 * 8;
                if (lim > NBITS) lim = NBITS;
                for (i = 0; i < lim; i++) shadow_map[i] = (op == bra_pkg::OP_FILL_SET);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        t_alloc_result got;
        if (!i_rst_n) begin
            shadow_map = '0;
            shadow_size = 11'd1024;
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) shadow_size = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = '{i_success, i_result_index, i_result_count};
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("Unexpected result %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        if (o_errors < 10)
                            $display("Mismatch: expected %p, got %p", exp_r, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_allocation(bra_pkg::t_op'(i_operation), int'(i_position_index),
                                   int'(i_run_length), exp_r);
                expected_q.push_back(exp_r);
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

[tb/bitmap_range_allocator_top_tb.sv]
`default_nettype none

module bitmap_range_allocator_top_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  operation = '0;
    logic [10:0] position_index = '0;
    logic [10:0] run_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        success;
    logic [9:0]  result_index;
    logic [10:0] result_count;
    int          errors, pending, results;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          quiet_sink = 1'b0;
    int          requests_sent = 0;
    logic [10:0] size_now = 11'd1024;

    localparam int WATCHDOG = 20000;

    bitmap_range_allocator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_operation(operation), .i_position_index(position_index),
        .i_run_length(run_length),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_success(success), .o_result_index(result_index),
        .o_result_count(result_count)
    );

    bitmap_range_allocator_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_operation(operation), .i_position_index(position_index),
        .i_run_length(run_length),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_success(success), .i_result_index(result_index),
        .i_result_count(result_count),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The receiver stalls at random, for one long stretch when asked, and not at all while quiet_sink is set.
    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (quiet_sink) begin
                out_ready <= 1'b1;
            end else begin
                g = gap_length();
                out_ready <= (g == 0);
                if (g > 0) repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("bitmap_range_allocator_top_tb failed");
            $finish;
        end
    end

    task automatic send_request(input bra_pkg::t_op op, input int pos, input int len,
                                input bit pace);
        int g;
        g = pace ? gap_length() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        position_index <= 11'(pos);
        run_length <= 11'(len);
        do @(posedge i_clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_size(input int sz);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= 11'(sz);
        size_now = 11'(sz);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_field(input int sz);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 2047);
        if (r < 3) return $urandom_range(0, 8);
        return $urandom_range(0, (sz > 0) ? sz : 1);
    endfunction

    task automatic random_phase(input int n);
        bra_pkg::t_op op;
        int sz, pos, len, r;
        sz = (size_now > 1024) ? 1024 : int'(size_now);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            pos = pick_field(sz);
            len = pick_field(sz);
            if (r < 25) op = bra_pkg::t_op'($urandom_range(0, 1));
            else if (r < 45) op = bra_pkg::t_op'($urandom_range(4, 7));
            else if (r < 48) op = bra_pkg::t_op'($urandom_range(14, 15));
            else op = bra_pkg::t_op'($urandom_range(0, 15));
            if (op <= bra_pkg::OP_CLEAR || op == bra_pkg::OP_FIND_SET ||
                op == bra_pkg::OP_FIND_CLEAR)
                len = (len > 64 && $urandom_range(0, 3) != 0) ? len % 64 : len;
            send_request(op, pos, len, 1'b1);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(bra_pkg::OP_COUNT_CLEAR, 0, 0, 0);
        send_request(bra_pkg::OP_LONG_SET, 0, 0, 0);
        send_request(bra_pkg::OP_SET, 0, 1, 0);
        send_request(bra_pkg::OP_SET, 1023, 5, 0);
        send_request(bra_pkg::OP_SET, 1024, 3, 0);
        send_request(bra_pkg::OP_SET, 2047, 2047, 0);
        send_request(bra_pkg::OP_TEST_SET, 1023, 1, 0);
        send_request(bra_pkg::OP_TEST_SET, 1023, 2, 0);
        send_request(bra_pkg::OP_TEST_CLEAR, 5, 0, 0);
        send_request(bra_pkg::OP_TEST_CLEAR, 1, 1022, 0);
        send_request(bra_pkg::OP_FIND_CLEAR, 2000, 10, 0);
        send_request(bra_pkg::OP_FIND_CLEAR, 0, 0, 0);
        send_request(bra_pkg::OP_FIND_SET, 0, 1025, 0);
        send_request(bra_pkg::OP_CLAIM_CLEAR, 100, 50, 0);
        send_request(bra_pkg::OP_CLAIM_SET, 120, 10, 0);
        send_request(bra_pkg::OP_FIRST_SET, 0, 0, 0);
        send_request(bra_pkg::OP_FIRST_CLEAR, 1023, 0, 0);
        send_request(bra_pkg::OP_FIRST_SET, 1024, 0, 0);
        send_request(bra_pkg::OP_LONG_CLEAR, 0, 0, 0);
        send_request(bra_pkg::OP_COUNT_SET, 0, 0, 0);
        send_request(bra_pkg::OP_FILL_SET, 0, 0, 0);
        send_request(bra_pkg::OP_FIND_CLEAR, 0, 1, 0);
        send_request(bra_pkg::OP_FILL_CLEAR, 0, 0, 0);
        send_request(bra_pkg::OP_CLAIM_CLEAR, 0, 1024, 0);
        send_request(bra_pkg::OP_LONG_SET, 0, 0, 0);

        hold_off = 1'b1;
        random_phase(30);
        random_phase(300);

        write_size(13);
        send_request(bra_pkg::OP_FILL_SET, 0, 0, 0);
        send_request(bra_pkg::OP_COUNT_SET, 0, 0, 0);
        random_phase(250);
        write_size(0);
        random_phase(40);
        write_size(2047);
        random_phase(250);
        write_size(1);
        random_phase(80);
        write_size($urandom_range(2, 200));
        quiet_sink = 1'b1;
        random_phase(200);
        quiet_sink = 1'b0;
        write_size(1024);
        random_phase(475);
        drain_results();

        $display("Sent %0d requests over map sizes 1024, 13, 0, 2047, 1 and random;",
                 requests_sent);
        $display("checked %0d results with %0d mismatches.", results, errors);
        if (errors == 0)
            $display("bitmap_range_allocator_top_tb passed");
        else
            $display("bitmap_range_allocator_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
